// File: rtl/fcct_pkg.sv
`timescale 1ns / 1ps
package fcct_pkg;

  typedef enum logic [2:0] {
    OP_WRITE   = 3'd0,
    OP_READ    = 3'd1,
    OP_TRIGGER = 3'd2,
    OP_RELOAD  = 3'd3,
    OP_ADVANCE = 3'd4,
    OP_ACK     = 3'd5,
    OP_RETI    = 3'd6,
    OP_NONE    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    IS_NONE    = 2'd0,
    IS_PENDING = 2'd1,
    IS_RAISED  = 2'd2,
    IS_SERVICE = 2'd3
  } int_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHAN,
    ST_TIMER,
    ST_COUNT,
    ST_DONE
  } state_t;

  localparam logic [7:0] CW_INT     = 8'h80;
  localparam logic [7:0] CW_COUNTER = 8'h40;
  localparam logic [7:0] CW_PRE256  = 8'h20;
  localparam logic [7:0] CW_TRIGGER = 8'h08;
  localparam logic [7:0] CW_CONST   = 8'h04;
  localparam logic [7:0] CW_RESET   = 8'h02;
  localparam logic [7:0] CW_CONTROL = 8'h01;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] channel;
    logic [7:0] value;
    logic [9:0] clocks;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       ack_valid;
    logic [7:0] ack_vector;
    logic       reti_hit;
    logic       int_raised;
    logic       int_pending;
  } out_item_t;

endpackage

// File: rtl/fcct_int_ctrl.sv
`timescale 1ns / 1ps
module fcct_int_ctrl #(
  parameter int CHANNELS = 4
) (
  input  logic [CHANNELS-1:0][1:0] status,
  output logic [CHANNELS-1:0][1:0] status_raised,
  output logic                     any_raised
);
  import fcct_pkg::*;

  // Raise every pending channel ahead of the first raised or in-service one.
  always_comb begin
    logic stop;
    stop = 1'b0;
    any_raised = 1'b0;
    status_raised = status;
    for (int i = 0; i < CHANNELS; i++) begin
      if (status[i] == IS_RAISED || status[i] == IS_SERVICE) begin
        stop = 1'b1;
      end
      if (!stop && status[i] == IS_PENDING) begin
        status_raised[i] = IS_RAISED;
        any_raised = 1'b1;
      end
    end
  end
endmodule

// File: rtl/four_channel_counter_timer.sv
`timescale 1ns / 1ps
// Four-channel counter/timer in the style of a classic CPU peripheral. Each
// input transaction is one operation (bus write, counter read, trigger,
// reload, advance by system clocks, interrupt acknowledge, return from
// interrupt) and yields exactly one result transaction. Bus operations are
// accepted, executed and presented in turn. An advance runs a small
// sequencer: it first subtracts repeatedly for the divide-by-EXT_DIVIDE
// clock prescaler, then visits each channel and, for a running timer or a
// counting channel 1 or 2, consumes one prescaler period or counter wrap
// per step, all through one shared 17-bit subtract and compare, so the
// length of an advance is set by the single subtract unit. The block is
// not ready while an operation is in progress, and a result waits in the
// output register until it is taken.
module four_channel_counter_timer #(
  parameter int CHANNELS    = 4,
  parameter int MAX_ADVANCE = 1023,
  parameter int EXT_DIVIDE  = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  fcct_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output fcct_pkg::out_item_t   out_data
);
  import fcct_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW = 17;
  localparam int RW = $clog2(EXT_DIVIDE + 1);

  state_t state, state_next;

  logic [CHANNELS-1:0][7:0] control_word;
  logic [CHANNELS-1:0][7:0] prescale_count;
  logic [CHANNELS-1:0][7:0] time_constant;
  logic [CHANNELS-1:0][7:0] down_count;
  logic [CHANNELS-1:0]      running;
  logic [CHANNELS-1:0][1:0] int_status;
  logic [4:0]               vector_base;
  logic [RW-1:0]            clock_remainder;

  in_item_t  item;
  out_item_t result;
  logic      raised_acc;

  // Advance working registers: clks for timers, ticks for counters.
  logic [AW-1:0] clks, total, ticks, work;
  logic [CW-1:0] ch;
  logic [8:0]    cntr;
  logic [AW-1:0] adv_clks;

  // Shared subtract/compare unit.
  logic [AW-1:0] sub_a, sub_b, sub_d;
  logic          sub_lt;
  assign sub_d  = sub_a - sub_b;
  assign sub_lt = sub_a < sub_b;

  logic [CHANNELS-1:0][1:0] st_in, st_raised;
  logic any_raised;
  fcct_int_ctrl #(.CHANNELS(CHANNELS)) u_int (
    .status(st_in), .status_raised(st_raised), .any_raised(any_raised));

  logic ok;
  logic [CW-1:0] ich;
  assign ok  = 32'(item.channel) < CHANNELS;
  assign ich = item.channel[CW-1:0];

  logic [7:0] cw_c;
  logic [8:0] pre_c, cons_c;
  assign cw_c   = control_word[ch];
  assign pre_c  = (prescale_count[ch] == 8'd0) ? 9'h100 : {1'b0, prescale_count[ch]};
  assign cons_c = (time_constant[ch] == 8'd0) ? 9'h100 : {1'b0, time_constant[ch]};

  // Per-channel decisions of an advance.
  logic chan_live, is_timer, enter_timer, enter_count, last_ch, timer_end, count_end;
  assign chan_live   = (cw_c & (CW_CONST | CW_RESET)) == 8'd0;
  assign is_timer    = (cw_c & CW_COUNTER) == 8'd0;
  assign enter_timer = chan_live && is_timer && running[ch];
  assign enter_count = chan_live && !is_timer && (32'(ch) == 1 || 32'(ch) == 2);
  assign last_ch     = 32'(ch) == CHANNELS - 1;
  assign timer_end   = (clks == '0) || sub_lt;
  assign count_end   = (work == '0) || sub_lt;

  assign adv_clks = (32'(in_data.clocks) > MAX_ADVANCE) ?
                    AW'(MAX_ADVANCE) : AW'(in_data.clocks);

  // The acknowledge serves the highest-priority raised channel.
  logic          ack_hit;
  logic [CW-1:0] ack_idx;
  always_comb begin
    ack_hit = 1'b0;
    ack_idx = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (int_status[i] == IS_RAISED) begin
        ack_hit = 1'b1;
        ack_idx = CW'(i);
      end
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_DONE);

  always_comb begin
    unique case (state)
      ST_TIMER: begin
        sub_a = clks;
        sub_b = AW'(pre_c);
      end
      ST_COUNT: begin
        sub_a = work;
        sub_b = AW'(cntr);
      end
      default: begin
        sub_a = total;
        sub_b = AW'(EXT_DIVIDE);
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = (in_data.op == OP_ADVANCE) ? ST_DIV : ST_CHAN;
      end
      ST_DIV: begin
        if (sub_lt) state_next = ST_CHAN;
      end
      ST_CHAN: begin
        if (item.op != OP_ADVANCE) state_next = ST_DONE;
        else if (enter_timer) state_next = ST_TIMER;
        else if (enter_count) state_next = ST_COUNT;
        else if (last_ch) state_next = ST_DONE;
      end
      ST_TIMER: begin
        if (timer_end) state_next = last_ch ? ST_DONE : ST_CHAN;
      end
      ST_COUNT: begin
        if (count_end) state_next = last_ch ? ST_DONE : ST_CHAN;
      end
      ST_DONE: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        control_word[i]   <= CW_RESET | CW_CONTROL;
        prescale_count[i] <= 8'd0;
        time_constant[i]  <= 8'd0;
        down_count[i]     <= 8'd0;
        running[i]        <= 1'b0;
        int_status[i]     <= IS_NONE;
      end
      vector_base     <= 5'd0;
      clock_remainder <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            item       <= in_data;
            raised_acc <= 1'b0;
            result     <= '0;
            clks       <= adv_clks;
            total      <= adv_clks + AW'(clock_remainder);
            ticks      <= '0;
            ch         <= '0;
          end
        end
        ST_DIV: begin
          if (sub_lt) begin
            clock_remainder <= total[RW-1:0];
          end else begin
            total <= sub_d;
            ticks <= ticks + AW'(1);
          end
        end
        ST_CHAN: begin
          unique case (item.op)
            OP_WRITE: if (ok) begin
              if ((control_word[ich] & CW_CONST) != 8'd0) begin
                control_word[ich]  <= control_word[ich] & ~(CW_CONST | CW_RESET);
                time_constant[ich] <= item.value;
                down_count[ich]    <= item.value;
              end else if (item.value[0]) begin
                control_word[ich] <= item.value;
                if ((item.value & CW_RESET) != 8'd0) begin
                  running[ich]        <= 1'b0;
                  prescale_count[ich] <= ((item.value & CW_PRE256) != 8'd0) ? 8'd0 : 8'd16;
                  int_status[ich]     <= IS_NONE;
                end
              end else if (ich == '0) begin
                vector_base   <= item.value[7:3];
                int_status[0] <= IS_NONE;
              end
            end
            OP_READ: if (ok) result.data_out <= down_count[ich];
            OP_TRIGGER: begin
              if (ok && (control_word[ich] & (CW_CONST | CW_RESET)) == 8'd0) begin
                if ((control_word[ich] & CW_COUNTER) != 8'd0) begin
                  if (down_count[ich] == 8'd1) begin
                    down_count[ich] <= time_constant[ich];
                    if ((control_word[ich] & CW_INT) != 8'd0 &&
                        int_status[ich] == IS_NONE) begin
                      int_status <= st_raised;
                      raised_acc <= any_raised;
                    end
                  end else begin
                    down_count[ich] <= down_count[ich] - 8'd1;
                  end
                end else if ((control_word[ich] & CW_TRIGGER) != 8'd0) begin
                  running[ich] <= 1'b1;
                end
              end
            end
            OP_RELOAD: if (ok) begin
              down_count[ich]     <= time_constant[ich];
              prescale_count[ich] <= ((control_word[ich] & CW_PRE256) != 8'd0) ? 8'd0 : 8'd16;
            end
            OP_ACK: begin
              if (ack_hit) begin
                int_status[ack_idx] <= IS_SERVICE;
                result.ack_valid    <= 1'b1;
                result.ack_vector   <= {vector_base, 3'({ack_idx, 1'b0})};
              end
            end
            OP_RETI: begin
              if (st_in != int_status) begin
                int_status      <= st_raised;
                result.reti_hit <= 1'b1;
                raised_acc      <= any_raised;
              end
            end
            OP_ADVANCE: begin
              // Visit one channel; timers and counters hand over to loops.
              if (enter_timer) begin
                work <= clks;
              end else if (enter_count) begin
                cntr <= (down_count[ch] == 8'd0) ? 9'h100 : {1'b0, down_count[ch]};
                work <= ticks;
              end else begin
                if (chan_live && is_timer && (cw_c & CW_TRIGGER) == 8'd0) begin
                  running[ch] <= 1'b1;
                end
                if (!last_ch) ch <= ch + CW'(1);
              end
            end
            default: ;
          endcase
        end
        ST_TIMER: begin
          // One prescaler period per cycle; clks holds what is left.
          if (timer_end) begin
            if (clks != '0) prescale_count[ch] <= prescale_count[ch] - clks[7:0];
            clks <= work;
            if (!last_ch) ch <= ch + CW'(1);
          end else begin
            clks <= sub_d;
            prescale_count[ch] <= ((cw_c & CW_PRE256) != 8'd0) ? 8'd0 : 8'd16;
            if (down_count[ch] == 8'd1) begin
              down_count[ch] <= time_constant[ch];
              if ((cw_c & CW_INT) != 8'd0 && int_status[ch] == IS_NONE) begin
                int_status <= st_raised;
                if (any_raised) raised_acc <= 1'b1;
              end
            end else begin
              down_count[ch] <= down_count[ch] - 8'd1;
            end
          end
        end
        ST_COUNT: begin
          if (count_end) begin
            down_count[ch] <= (work == '0) ? cntr[7:0] : 8'(cntr - work[8:0]);
            if (!last_ch) ch <= ch + CW'(1);
          end else begin
            work <= sub_d;
            cntr <= cons_c;
            if ((cw_c & CW_INT) != 8'd0 && int_status[ch] == IS_NONE) begin
              int_status <= st_raised;
              if (any_raised) raised_acc <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Interrupt unit input: a channel whose count hit zero enters pending
  // before the raise pass; on return from interrupt the first in-service
  // channel is ended first.
  always_comb begin
    logic found;
    found = 1'b0;
    st_in = int_status;
    if (state == ST_CHAN && item.op == OP_RETI) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (!found && int_status[i] == IS_SERVICE) begin
          st_in[i] = IS_NONE;
          found = 1'b1;
        end
      end
    end else if (state == ST_CHAN && item.op == OP_TRIGGER && ok) begin
      if (int_status[ich] == IS_NONE) st_in[ich] = IS_PENDING;
    end else if (state == ST_TIMER || state == ST_COUNT) begin
      if (int_status[ch] == IS_NONE) st_in[ch] = IS_PENDING;
    end
  end

  // Result flags are finished when the sequencer enters the done state.
  logic any_pend;
  always_comb begin
    any_pend = 1'b0;
    for (int i = 0; i < CHANNELS; i++)
      if (int_status[i] != IS_NONE) any_pend = 1'b1;
  end

  logic [1:0] flags;
  assign flags = {raised_acc, any_pend};
  out_item_t shown;
  always_comb begin
    shown = result;
    shown.int_raised  = flags[1];
    shown.int_pending = flags[0];
  end
  assign out_data = shown;

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("result shown while idle");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid) |=> state != ST_IDLE)
    else $error("accepted transaction lost");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import fcct_pkg::*;

  // Clock and reset. Reset is synchronous and held high at the start.
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  // Input side: the testbench drives valid and payload, the block drives stall.
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;

  // Output side: the block drives valid and payload, the testbench drives stall.
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;

  four_channel_counter_timer uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Shadow copy of the block's state. It is updated as each input transaction
  // is accepted, so that every expected result is ready before the block
  // presents its own.
  logic [7:0]  sh_cw    [4];
  logic [7:0]  sh_pre   [4];
  logic [7:0]  sh_tc    [4];
  logic [7:0]  sh_down  [4];
  logic        sh_run   [4];
  int_state_t  sh_ist   [4];
  logic [4:0]  sh_vbase;
  int unsigned sh_rem;
  logic        sh_raised;

  // Results the block still owes, oldest first.
  out_item_t owed_results[$];
  int        errors = 0;

  task automatic shadow_reset();
    for (int i = 0; i < 4; i++) begin
      sh_cw[i] = CW_RESET | CW_CONTROL;
      sh_pre[i] = '0;
      sh_tc[i] = '0;
      sh_down[i] = '0;
      sh_run[i] = 1'b0;
      sh_ist[i] = IS_NONE;
    end
    sh_vbase = '0;
    sh_rem = 0;
  endtask

  // Walk the channels by priority; pending channels ahead of the first raised
  // or in-service one get raised.
  function automatic void raise_walk();
    for (int i = 0; i < 4; i++) begin
      if (sh_ist[i] == IS_RAISED || sh_ist[i] == IS_SERVICE) break;
      if (sh_ist[i] == IS_PENDING) begin
        sh_ist[i] = IS_RAISED;
        sh_raised = 1'b1;
      end
    end
  endfunction

  function automatic void reached_zero(int c);
    if ((sh_cw[c] & CW_INT) != 0 && sh_ist[c] == IS_NONE) begin
      sh_ist[c] = IS_PENDING;
      raise_walk();
    end
  endfunction

  function automatic logic [7:0] prescale_start(int c);
    return ((sh_cw[c] & CW_PRE256) != 0) ? 8'd0 : 8'd16;
  endfunction

  function automatic void step_channel(int c, int unsigned clks, int unsigned ticks);
    int unsigned pre, cntr, cons;
    if ((sh_cw[c] & (CW_CONST | CW_RESET)) != 0) return;
    if ((sh_cw[c] & CW_COUNTER) == 0) begin
      // A stopped timer is only started here, if it needs no trigger, without consuming clocks.
      if (!sh_run[c]) begin
        if ((sh_cw[c] & CW_TRIGGER) == 0) sh_run[c] = 1'b1;
        return;
      end
      while (clks > 0) begin
        pre = (sh_pre[c] == 0) ? 256 : sh_pre[c];
        if (clks < pre) begin
          sh_pre[c] = sh_pre[c] - clks[7:0];
          break;
        end
        clks -= pre;
        sh_pre[c] = prescale_start(c);
        sh_down[c] = sh_down[c] - 8'd1;
        if (sh_down[c] == 0) begin
          sh_down[c] = sh_tc[c];
          reached_zero(c);
        end
      end
    end else if (c == 1 || c == 2) begin
      // Counter mode on channels 1 and 2 also counts the divided system clock.
      cntr = (sh_down[c] == 0) ? 256 : sh_down[c];
      cons = (sh_tc[c] == 0) ? 256 : sh_tc[c];
      while (ticks > 0) begin
        if (cntr <= ticks) begin
          ticks -= cntr;
          cntr = cons;
          reached_zero(c);
        end else begin
          cntr -= ticks;
          break;
        end
      end
      sh_down[c] = cntr[7:0];
    end
  endfunction

  // Apply one operation to the shadow state and return the result it causes.
  function automatic out_item_t ctc_predict(in_item_t it);
    out_item_t r;
    int c;
    int unsigned clks, total, ticks;
    r = '0;
    c = it.channel;
    sh_raised = 1'b0;
    case (op_t'(it.op))
      OP_WRITE: begin
        if ((sh_cw[c] & CW_CONST) != 0) begin
          sh_cw[c] = sh_cw[c] & ~(CW_CONST | CW_RESET);
          sh_tc[c] = it.value;
          sh_down[c] = it.value;
        end else if ((it.value & CW_CONTROL) != 0) begin
          sh_cw[c] = it.value;
          if ((it.value & CW_RESET) != 0) begin
            sh_run[c] = 1'b0;
            sh_pre[c] = prescale_start(c);
            sh_ist[c] = IS_NONE;
          end
        end else if (c == 0) begin
          // Vector writes only land on channel 0; elsewhere they are stray.
          sh_vbase = it.value[7:3];
          sh_ist[0] = IS_NONE;
        end
      end
      OP_READ: r.data_out = sh_down[c];
      OP_TRIGGER: begin
        if ((sh_cw[c] & (CW_CONST | CW_RESET)) == 0) begin
          if ((sh_cw[c] & CW_COUNTER) != 0) begin
            sh_down[c] = sh_down[c] - 8'd1;
            if (sh_down[c] == 0) begin
              sh_down[c] = sh_tc[c];
              reached_zero(c);
            end
          end else if ((sh_cw[c] & CW_TRIGGER) != 0) begin
            sh_run[c] = 1'b1;
          end
        end
      end
      OP_RELOAD: begin
        sh_down[c] = sh_tc[c];
        sh_pre[c] = prescale_start(c);
      end
      OP_ADVANCE: begin
        clks = it.clocks;
        if (clks > 1023) clks = 1023;
        total = sh_rem + clks;
        ticks = total / 13;
        sh_rem = total % 13;
        for (int i = 0; i < 4; i++) step_channel(i, clks, ticks);
      end
      OP_ACK: begin
        for (int i = 0; i < 4; i++) begin
          if (sh_ist[i] == IS_RAISED) begin
            sh_ist[i] = IS_SERVICE;
            r.ack_valid = 1'b1;
            r.ack_vector = {sh_vbase, i[1:0], 1'b0};
            break;
          end
        end
      end
      OP_RETI: begin
        for (int i = 0; i < 4; i++) begin
          if (sh_ist[i] == IS_SERVICE) begin
            sh_ist[i] = IS_NONE;
            r.reti_hit = 1'b1;
            raise_walk();
            break;
          end
        end
      end
      default: ;
    endcase
    r.int_raised = sh_raised;
    for (int i = 0; i < 4; i++) if (sh_ist[i] != IS_NONE) r.int_pending = 1'b1;
    return r;
  endfunction

  // Directed stimulus. Rows with a typed-in result check it against the
  // predictor as well, so a slip in either shows up.
  typedef struct {
    in_item_t  item;
    logic      fixed;
    out_item_t want;
  } step_row_t;

  function automatic in_item_t mk(op_t o, int c, int v, int k);
    in_item_t t;
    t.op = o;
    t.channel = c[1:0];
    t.value = v[7:0];
    t.clocks = k[9:0];
    return t;
  endfunction

  function automatic out_item_t res(int d, int a, int vec, int rt, int rs, int pd);
    out_item_t r;
    r.data_out = d[7:0];
    r.ack_valid = a[0];
    r.ack_vector = vec[7:0];
    r.reti_hit = rt[0];
    r.int_raised = rs[0];
    r.int_pending = pd[0];
    return r;
  endfunction

  step_row_t script[$];

  task automatic add(in_item_t it, logic fx = 1'b0, out_item_t w = '0);
    step_row_t s;
    s.item = it;
    s.fixed = fx;
    s.want = w;
    script.push_back(s);
  endtask

  task automatic build_script();
    // After reset every counter reads zero and nothing is pending.
    add(mk(OP_READ, 0, 0, 0), 1'b1, res(0, 0, 0, 0, 0, 0));
    add(mk(OP_READ, 3, 0, 0), 1'b1, res(0, 0, 0, 0, 0, 0));
    // A channel in reset ignores triggers and advances.
    add(mk(OP_TRIGGER, 0, 0, 0));
    add(mk(OP_ADVANCE, 0, 0, 1023));
    // Vector base from the top five bits; a stray vector write on channel 3.
    add(mk(OP_WRITE, 0, 8'hf8, 0));
    add(mk(OP_WRITE, 3, 8'h50, 0));
    // Channel 0: timer, prescaler 16, interrupts on, constant 1.
    add(mk(OP_WRITE, 0, CW_INT | CW_CONST | CW_RESET | CW_CONTROL, 0));
    add(mk(OP_WRITE, 0, 1, 0));
    add(mk(OP_ADVANCE, 0, 0, 0));           // timer start, no clocks used
    add(mk(OP_ADVANCE, 0, 0, 16), 1'b1, res(0, 0, 0, 0, 1, 1));
    add(mk(OP_ACK, 0, 0, 0), 1'b1, res(0, 1, 8'hf8, 0, 0, 1));
    add(mk(OP_ACK, 0, 0, 0), 1'b1, res(0, 0, 0, 0, 0, 1));
    // Channel 1: counter mode with constant zero, fed by the divided clock.
    add(mk(OP_WRITE, 1, CW_INT | CW_COUNTER | CW_CONST | CW_CONTROL, 0));
    add(mk(OP_WRITE, 1, 0, 0));
    add(mk(OP_ADVANCE, 0, 0, 1023));
    add(mk(OP_RETI, 0, 0, 0), 1'b1, res(0, 0, 0, 1, 0, 0));
    add(mk(OP_TRIGGER, 1, 0, 0));
    add(mk(OP_READ, 1, 0, 0));
    // Channel 2: timer that waits for a trigger, prescaler 256.
    add(mk(OP_WRITE, 2, CW_TRIGGER | CW_PRE256 | CW_CONST | CW_CONTROL, 0));
    add(mk(OP_WRITE, 2, 8'hff, 0));
    add(mk(OP_ADVANCE, 0, 0, 600));
    add(mk(OP_TRIGGER, 2, 0, 0));
    add(mk(OP_ADVANCE, 0, 0, 700));
    add(mk(OP_RELOAD, 2, 0, 0));
    add(mk(OP_NONE, 3, 8'hff, 1023));
    add(mk(OP_ACK, 0, 0, 0));
    add(mk(OP_RETI, 0, 0, 0));
  endtask

  // Random traffic: mostly channels set up to tick and interrupt, then a mix
  // of advances, triggers, reads and interrupt handshakes with some noise.
  function automatic in_item_t rand_item();
    int unsigned pick, c, cw;
    pick = $urandom_range(0, 99);
    c = $urandom_range(0, 3);
    if (pick < 10) begin
      cw = $urandom_range(0, 255) | CW_CONTROL;
      if ($urandom_range(0, 3) != 0) cw = cw | CW_CONST;
      if ($urandom_range(0, 3) != 0) cw = cw | CW_INT;
      return mk(OP_WRITE, c, cw, $urandom_range(0, 1023));
    end else if (pick < 20) begin
      return mk(OP_WRITE, c, $urandom_range(0, 255), $urandom_range(0, 1023));
    end else if (pick < 42) begin
      return mk(OP_ADVANCE, c, $urandom_range(0, 255),
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                            : $urandom_range(0, 80));
    end else if (pick < 54) begin
      return mk(OP_TRIGGER, c, $urandom_range(0, 255), $urandom_range(0, 1023));
    end else if (pick < 64) begin
      return mk(OP_READ, c, $urandom_range(0, 255), $urandom_range(0, 1023));
    end else if (pick < 70) begin
      return mk(OP_RELOAD, c, $urandom_range(0, 255), $urandom_range(0, 1023));
    end else if (pick < 83) begin
      return mk(OP_ACK, c, $urandom_range(0, 255), $urandom_range(0, 1023));
    end else if (pick < 96) begin
      return mk(OP_RETI, c, $urandom_range(0, 255), $urandom_range(0, 1023));
    end
    return mk(OP_NONE, c, $urandom_range(0, 255), $urandom_range(0, 1023));
  endfunction

  // Offer one transaction at the falling edge and hold it until the block
  // accepts it at a rising edge. The expectation is queued on acceptance.
  task automatic send_item(in_item_t it, logic fx, out_item_t w);
    out_item_t p;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    p = ctc_predict(it);
    if (fx && p !== w) begin
      $display("%0t: directed row disagrees, typed %h predicted %h", $time, w, p);
      errors++;
    end
    owed_results.push_back(p);
    // A burst continues straight into the next item; otherwise drop valid.
    if ($urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  endtask

  // Receiver: stalls on its own pattern of quiet and busy stretches.
  initial begin
    int unsigned span;
    @(negedge clk);
    forever begin
      span = $urandom_range(1, 40);
      for (int i = 0; i < span; i++) begin
        @(negedge clk);
        out_stall <= (span > 20) ? 1'b0 : ($urandom_range(0, 2) == 0);
      end
    end
  end

  // Check every result transaction against the oldest expectation.
  always @(posedge clk) begin
    out_item_t w;
    if (!rst && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        w = owed_results.pop_front();
        if (out_data.data_out !== w.data_out) begin
          $display("%0t: data_out expected %h actual %h", $time, w.data_out,
                   out_data.data_out);
          errors++;
        end
        if (out_data.ack_valid !== w.ack_valid) begin
          $display("%0t: ack_valid expected %b actual %b", $time, w.ack_valid,
                   out_data.ack_valid);
          errors++;
        end
        if (out_data.ack_vector !== w.ack_vector) begin
          $display("%0t: ack_vector expected %h actual %h", $time, w.ack_vector,
                   out_data.ack_vector);
          errors++;
        end
        if (out_data.reti_hit !== w.reti_hit) begin
          $display("%0t: reti_hit expected %b actual %b", $time, w.reti_hit,
                   out_data.reti_hit);
          errors++;
        end
        if (out_data.int_raised !== w.int_raised) begin
          $display("%0t: int_raised expected %b actual %b", $time, w.int_raised,
                   out_data.int_raised);
          errors++;
        end
        if (out_data.int_pending !== w.int_pending) begin
          $display("%0t: int_pending expected %b actual %b", $time, w.int_pending,
                   out_data.int_pending);
          errors++;
        end
      end
    end
  end

  // Main sequence: reset, directed rows, random traffic, then drain.
  initial begin
    shadow_reset();
    build_script();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (script[i]) send_item(script[i].item, script[i].fixed, script[i].want);
    for (int n = 0; n < 700; n++) send_item(rand_item(), 1'b0, '0);
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    // Give a stray late result time to show up before the verdict.
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: about 730 items, each up to a worst-case advance, plus stalls,
  // with a wide margin on top.
  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
